[design/dps_pkg.sv]
// Shared types, constants and helpers for the delay path selector.
package dps_pkg;

    localparam int PATH_COUNT = 3;
    localparam int PATH_W     = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;

    localparam int PATH_ID_W  = 2;
    localparam int RTT_W      = 25;
    localparam int TIME_W     = 32;
    localparam int SRTT_W     = RTT_W + 3;
    localparam int HYST_W     = 24;
    localparam int ACTIVE_W   = 2;
    localparam int MASK_W     = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

    localparam logic [HYST_W-1:0] HYST_RESET  = 24'd10000;
    localparam logic [TIME_W-1:0] GUARD_RESET = 32'd1000000;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CHECK  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HYST   = 2'd0,
        REG_GUARD0 = 2'd1,
        REG_GUARD1 = 2'd2,
        REG_GUARD2 = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [HYST_W-1:0] hyst;
        logic [TIME_W-1:0] guard0;
        logic [TIME_W-1:0] guard1;
        logic [TIME_W-1:0] guard2;
    } cfg_t;

    typedef struct packed {
        cmd_t               command;
        logic [PATH_ID_W-1:0] path_id;
        logic [RTT_W-1:0]   rtt;
        logic [TIME_W-1:0]  now;
    } item_t;

    typedef struct packed {
        logic [PATH_COUNT-1:0][SRTT_W-1:0] srtt;
        logic [PATH_COUNT-1:0]             has_sample;
        logic [PATH_COUNT-1:0]             armed;
        logic [PATH_COUNT-1:0][TIME_W-1:0] start;
        logic [PATH_W-1:0]                 current;
    } state_t;

    typedef struct packed {
        logic [ACTIVE_W-1:0] active_path;
        logic                switched;
        logic [MASK_W-1:0]   armed_mask;
    } result_t;

    // paths beyond the third share the last guard time
    function automatic logic [TIME_W-1:0] guard_time_of(input cfg_t cfg, input int p);
        logic [TIME_W-1:0] gt;
        case (p)
            0:       gt = cfg.guard0;
            1:       gt = cfg.guard1;
            default: gt = cfg.guard2;
        endcase
        return gt;
    endfunction

endpackage

[design/dps_eval.sv]
// Next-state and result logic for one sample or check beat.
module dps_eval (
    input  dps_pkg::cfg_t    cfg,
    input  dps_pkg::state_t  state,
    input  dps_pkg::item_t   item,
    output dps_pkg::state_t  state_next,
    output dps_pkg::result_t result
);
    import dps_pkg::*;

    logic [SRTT_W+2:0]      seven_s;
    logic [SRTT_W-1:0]      srtt_blend;
    logic [SRTT_W:0]        srtt_sum;
    logic [SRTT_W-1:0]      srtt_upd;
    logic                   path_ok;
    logic                   is_sample;
    logic [PATH_COUNT-1:0]  target;
    logic [PATH_COUNT-1:0][SRTT_W-1:0] srtt_n;
    logic [PATH_COUNT-1:0]  has_n;
    logic                   all_sampled;
    logic [SRTT_W-1:0]      srtt_cur;
    logic [SRTT_W:0]        hyst8;
    logic [PATH_COUNT-1:0]  beats;
    logic [PATH_COUNT-1:0]  expired;
    logic [TIME_W-1:0]      elapsed;
    logic                   found;
    logic [PATH_W-1:0]      found_idx;
    logic [SRTT_W-1:0]      srtt_sel;

    always_comb
    begin
        is_sample = (item.command == CMD_SAMPLE);
        path_ok   = ({30'd0, item.path_id} < 32'(PATH_COUNT));

        srtt_sel = '0;
        for (int p = 0; p < PATH_COUNT; p++)
        begin
            target[p] = is_sample && path_ok && ({30'd0, item.path_id} == 32'(p));
            if (target[p])
                srtt_sel = state.srtt[p];
        end

        // rtt + round(7/8 * srtt)
        seven_s    = {srtt_sel, 3'b000} - {3'b000, srtt_sel};
        srtt_blend = SRTT_W'((seven_s + (SRTT_W+3)'(4)) >> 3);
        srtt_sum   = {1'b0, srtt_blend} + (SRTT_W+1)'(item.rtt);
        srtt_upd   = srtt_sum[SRTT_W-1:0];

        for (int p = 0; p < PATH_COUNT; p++)
        begin
            srtt_n[p] = state.srtt[p];
            has_n[p]  = state.has_sample[p] | target[p];
            if (target[p])
                srtt_n[p] = state.has_sample[p] ? srtt_upd : {item.rtt, 3'b000};
        end
        all_sampled = &has_n;

        srtt_cur = srtt_n[state.current];
        hyst8    = (SRTT_W+1)'({item.command == CMD_SAMPLE ? cfg.hyst : cfg.hyst, 3'b000});
        for (int p = 0; p < PATH_COUNT; p++)
            beats[p] = ({1'b0, srtt_cur} >= ({1'b0, srtt_n[p]} + hyst8));

        state_next            = state;
        state_next.srtt       = srtt_n;
        state_next.has_sample = has_n;
        result.switched       = 1'b0;
        expired               = '0;
        found                 = 1'b0;
        found_idx             = state.current;
        elapsed               = '0;

        if (is_sample)
        begin
            if (path_ok && all_sampled)
            begin
                for (int p = 0; p < PATH_COUNT; p++)
                begin
                    if ((32'(state.current) != 32'(p)) && beats[p] && !state.armed[p])
                    begin
                        state_next.armed[p] = 1'b1;
                        state_next.start[p] = item.now;
                    end
                end
            end
        end
        else
        begin
            // lowest expired path that still beats the active one wins
            for (int p = 0; p < PATH_COUNT; p++)
            begin
                elapsed    = item.now - state.start[p];
                expired[p] = state.armed[p] && (elapsed >= guard_time_of(cfg, p));
                if (!found && expired[p] && beats[p])
                begin
                    found     = 1'b1;
                    found_idx = PATH_W'(p);
                end
            end
            if (found)
            begin
                state_next.armed   = '0;
                state_next.current = found_idx;
                result.switched    = (found_idx != state.current);
            end
            else
            begin
                state_next.armed = state.armed & ~expired;
            end
        end

        result.active_path = ACTIVE_W'(state_next.current);
        result.armed_mask  = '0;
        for (int p = 0; p < PATH_COUNT; p++)
        begin
            if (p < MASK_W)
                result.armed_mask[p[1:0]] = state_next.armed[p];
        end
    end

endmodule

[design/delay_path_selector.sv]
// Delay path selector top level: input stage, state, config and result register.
// An accepted input beat is held in the input stage, then its result is held in the result register.
// Throughput: one beat per cycle while the output is not stalled; the state update is combinational logic in dps_eval.
// Output register frees the input stage whenever the result is taken or empty.
// Reset: rst_n async low; SRTTs, samples and guards clear, path 0 active,
// config registers return to defaults.
module delay_path_selector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dps_pkg::IN_DATA_W-1:0]     s_tdata,   // path_id, rtt_us, now_us
    input  logic                              s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dps_pkg::OUT_DATA_W-1:0]    m_tdata,   // active_path, switched, armed_mask
    input  logic                              cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dps_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    item_t   item_in;
    result_t res_next;
    result_t res_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;

    assign item_in.command = cmd_t'(s_tuser);
    assign item_in.path_id = s_tdata[1:0];
    assign item_in.rtt     = s_tdata[26:2];
    assign item_in.now     = s_tdata[58:27];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.armed_mask, res_reg.switched, res_reg.active_path};

    dps_eval u_eval (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hyst   <= HYST_RESET;
            cfg_reg.guard0 <= GUARD_RESET;
            cfg_reg.guard1 <= GUARD_RESET;
            cfg_reg.guard2 <= GUARD_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_HYST:   cfg_reg.hyst   <= cfg_data[HYST_W-1:0];
                REG_GUARD0: cfg_reg.guard0 <= cfg_data;
                REG_GUARD1: cfg_reg.guard1 <= cfg_data;
                REG_GUARD2: cfg_reg.guard2 <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= item_in;
        if (advance)
            res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_current_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(state_reg.current) < PATH_COUNT)
        else $error("active path out of range");

    a_active_not_armed: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.armed[state_reg.current])
        else $error("guard armed on the active path");

    a_armed_needs_samples: assert property (@(posedge clk) disable iff (!rst_n)
        (|state_reg.armed) |-> (&state_reg.has_sample))
        else $error("guard armed before every path has a sample");

    a_switch_clears_guards: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.switched) |=> (state_reg.armed == '0 && m_tdata[5:3] == 3'b000))
        else $error("guards still armed after a path switch");
`endif

endmodule
